@@ rtl/rau_pkg.sv @@
// Shared types and codes for the rational arithmetic unit.
// Used by rau_seq and rational_arithmetic_unit; depends on nothing else.
`timescale 1ns / 1ps

package rau_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned DEN_W   = 31;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // request as packed on the input stream, last field (mode) in the low bits
  typedef struct packed {
    logic [FIELD_W-1:0] right_den;
    logic [FIELD_W-1:0] right_num;
    logic [FIELD_W-1:0] left_den;
    logic [FIELD_W-1:0] left_num;
    mode_t              mode;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [DEN_W-1:0]   result_den;
    logic [FIELD_W-1:0] result_num;
  } res_t;

  localparam int unsigned REQ_W = $bits(req_t);
  localparam int unsigned RES_W = $bits(res_t);
  localparam int unsigned IN_TDATA_W  = ((REQ_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

@@ rtl/rational_arithmetic_unit.sv @@
// Rational add/subtract/multiply/divide with gcd reduction through one shared adder.
// Steps: two or three shift-add products, a signed sum (redone the other way round on a
// borrow), a data-dependent binary gcd, two restoring divisions and the result register;
// a zero denominator or a divide by zero goes straight to the result.
// One request at a time; the next is taken once the result has moved to the output register.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // mode[1:0], left_num[33:2], left_den[65:34], right_num[97:66],
  // right_den[129:98], zero fill above
  input  logic [rau_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_num[31:0], result_den[62:32], status[64:63], zero fill above
  output logic [rau_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  rau_pkg::req_t req;
  rau_pkg::res_t seq_res;
  rau_pkg::res_t out_res_r;
  logic          seq_res_valid;
  logic          seq_res_ready;
  logic          out_tvalid_r, out_tvalid_nxt;

  assign req = rau_pkg::req_t'(in_tdata[rau_pkg::REQ_W-1:0]);

  rau_seq #(
    .WIDTH (WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (seq_res_valid),
    .res_ready (seq_res_ready),
    .res       (seq_res)
  );

  // hold the result here so the sequencer can take the next request
  assign seq_res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (seq_res_valid && seq_res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res_valid && seq_res_ready) begin
      out_res_r <= seq_res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = rau_pkg::OUT_TDATA_W'(out_res_r);

endmodule

@@ rtl/rau_alu.sv @@
// Shared adder/subtractor of the rational arithmetic unit.
// Stand-alone; instantiated once by rau_seq.
`timescale 1ns / 1ps

module rau_alu #(
  parameter int unsigned AW = 65
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic          sub,
  output logic [AW-1:0] res
);

  logic [AW-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign res   = a + b_eff + {{(AW-1){1'b0}}, sub};

endmodule

@@ rtl/rau_seq.sv @@
// Sequencer and datapath registers: shift-add products, signed add, binary gcd,
// restoring divisions, all through one rau_alu. Uses rau_pkg and rau_alu.
`timescale 1ns / 1ps

module rau_seq #(
  parameter int unsigned WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  rau_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output rau_pkg::res_t res
);

  localparam int unsigned W  = WIDTH;
  localparam int unsigned M  = 2 * WIDTH;
  localparam int unsigned CW = $clog2(M);
  localparam logic [M-1:0] LIMIT = {{(M-1){1'b0}}, 1'b1} << (W - 1);

  localparam logic [1:0] PROD_A = 2'd0;  // first numerator product
  localparam logic [1:0] PROD_B = 2'd1;  // second numerator product
  localparam logic [1:0] PROD_D = 2'd2;  // denominator product

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_ADD   = 10'b0000000100,
    S_NEG   = 10'b0000001000,
    S_STRIP = 10'b0000010000,
    S_GA    = 10'b0000100000,
    S_GB    = 10'b0001000000,
    S_DIVN  = 10'b0010000000,
    S_DIVD  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t           state_r, state_nxt;
  rau_pkg::mode_t   mode_r, mode_nxt;
  rau_pkg::status_t status_r, status_nxt;
  logic [W-1:0]     an_r, an_nxt, ad_r, ad_nxt, cn_r, cn_nxt, cd_r, cd_nxt;
  logic             s0_r, s0_nxt, s1_r, s1_nxt, neg_r, neg_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [M-1:0]     num_r, num_nxt, den_r, den_nxt, ga_r, ga_nxt, gb_r, gb_nxt;

  logic [M:0]       alu_a, alu_b, alu_res;
  logic             alu_sub;
  logic [W-1:0]     mcand, mplier;
  logic             mbit, addsub;
  logic [W-1:0]     in_an, in_ad, in_cn, in_cd;
  logic             in_ln, in_ld, in_rn, in_rd;
  logic             ovf;
  logic [W-1:0]     onum;

  function automatic logic [W-1:0] take_mag(input logic [rau_pkg::FIELD_W-1:0] f);
    logic [W-1:0] v;
    v = f[W-1:0];
    return v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
  endfunction

  assign in_an = take_mag(req.left_num);
  assign in_ad = take_mag(req.left_den);
  assign in_cn = take_mag(req.right_num);
  assign in_cd = take_mag(req.right_den);
  assign in_ln = req.left_num[W-1];
  assign in_ld = req.left_den[W-1];
  assign in_rn = req.right_num[W-1];
  assign in_rd = req.right_den[W-1];

  assign addsub = (mode_r == rau_pkg::MODE_ADD) || (mode_r == rau_pkg::MODE_SUB);

  always_comb begin
    case (idx_r)
      PROD_A: begin
        mcand  = an_r;
        mplier = (mode_r == rau_pkg::MODE_MUL) ? cn_r : cd_r;
      end
      PROD_B: begin
        mcand  = cn_r;
        mplier = ad_r;
      end
      default: begin
        mcand  = ad_r;
        mplier = (mode_r == rau_pkg::MODE_DIV) ? cn_r : cd_r;
      end
    endcase
  end

  assign mbit = mplier[cnt_r[CW-2:0]];

  // operand steering for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_MUL: begin
        alu_a = {ga_r, 1'b0};
        alu_b = mbit ? (M+1)'(mcand) : '0;
      end
      S_ADD: begin
        alu_a   = {1'b0, num_r};
        alu_b   = {1'b0, gb_r};
        alu_sub = s0_r ^ s1_r;
      end
      S_NEG: begin
        alu_a   = {1'b0, gb_r};
        alu_b   = {1'b0, num_r};
        alu_sub = 1'b1;
      end
      S_GB: begin
        alu_a   = {1'b0, gb_r};
        alu_b   = {1'b0, ga_r};
        alu_sub = 1'b1;
      end
      S_DIVN: begin
        alu_a   = {gb_r, num_r[M-1]};
        alu_b   = {1'b0, ga_r};
        alu_sub = 1'b1;
      end
      S_DIVD: begin
        alu_a   = {gb_r, den_r[M-1]};
        alu_b   = {1'b0, ga_r};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  rau_alu #(
    .AW (M + 1)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    status_nxt = status_r;
    an_nxt     = an_r;
    ad_nxt     = ad_r;
    cn_nxt     = cn_r;
    cd_nxt     = cd_r;
    s0_nxt     = s0_r;
    s1_nxt     = s1_r;
    neg_nxt    = neg_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    ga_nxt     = ga_r;
    gb_nxt     = gb_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          mode_nxt = req.mode;
          an_nxt   = in_an;
          ad_nxt   = in_ad;
          cn_nxt   = in_cn;
          cd_nxt   = in_cd;
          s0_nxt   = in_ln ^ in_ld;
          s1_nxt   = in_rn ^ in_rd ^ (req.mode == rau_pkg::MODE_SUB);
          neg_nxt  = in_ln ^ in_ld ^ in_rn ^ in_rd;
          idx_nxt  = PROD_A;
          cnt_nxt  = CW'(W - 1);
          ga_nxt   = '0;
          if (in_ad == '0 || in_cd == '0) begin
            status_nxt = rau_pkg::ST_ZERO_DEN;
            state_nxt  = S_DONE;
          end else if (req.mode == rau_pkg::MODE_DIV && in_cn == '0) begin
            status_nxt = rau_pkg::ST_DIV_ZERO;
            state_nxt  = S_DONE;
          end else begin
            status_nxt = rau_pkg::ST_OK;
            state_nxt  = S_MUL;
          end
        end
      end
      S_MUL: begin
        ga_nxt = alu_res[M-1:0];
        if (cnt_r == '0) begin
          cnt_nxt = CW'(W - 1);
          ga_nxt  = '0;
          case (idx_r)
            PROD_A: begin
              num_nxt = alu_res[M-1:0];
              idx_nxt = addsub ? PROD_B : PROD_D;
            end
            PROD_B: begin
              gb_nxt  = alu_res[M-1:0];
              idx_nxt = PROD_D;
            end
            default: begin
              den_nxt   = alu_res[M-1:0];
              state_nxt = addsub ? S_ADD : S_STRIP;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ADD: begin
        // a borrow means the second product is larger: redo the other way round
        if (alu_sub && alu_res[M]) begin
          state_nxt = S_NEG;
        end else begin
          num_nxt   = alu_res[M-1:0];
          neg_nxt   = s0_r;
          state_nxt = S_STRIP;
        end
      end
      S_NEG: begin
        num_nxt   = alu_res[M-1:0];
        neg_nxt   = s1_r;
        state_nxt = S_STRIP;
      end
      S_STRIP: begin
        // drop common factors of two from both terms before the odd gcd
        if (num_r == '0) begin
          neg_nxt   = 1'b0;
          den_nxt   = {{(M-1){1'b0}}, 1'b1};
          state_nxt = S_DONE;
        end else if (num_r[0] || den_r[0]) begin
          ga_nxt    = num_r;
          gb_nxt    = den_r;
          state_nxt = S_GA;
        end else begin
          num_nxt = num_r >> 1;
          den_nxt = den_r >> 1;
        end
      end
      S_GA: begin
        if (ga_r[0]) begin
          state_nxt = S_GB;
        end else begin
          ga_nxt = ga_r >> 1;
        end
      end
      S_GB: begin
        if (gb_r == '0) begin
          cnt_nxt   = CW'(M - 1);
          state_nxt = S_DIVN;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (alu_res[M]) begin
          ga_nxt = gb_r;
          gb_nxt = ga_r;
        end else begin
          gb_nxt = {1'b0, alu_res[M-1:1]};
        end
      end
      S_DIVN: begin
        gb_nxt  = alu_res[M] ? alu_a[M-1:0] : alu_res[M-1:0];
        num_nxt = {num_r[M-2:0], ~alu_res[M]};
        if (cnt_r == '0) begin
          cnt_nxt   = CW'(M - 1);
          gb_nxt    = '0;
          state_nxt = S_DIVD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DIVD: begin
        gb_nxt  = alu_res[M] ? alu_a[M-1:0] : alu_res[M-1:0];
        den_nxt = {den_r[M-2:0], ~alu_res[M]};
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= PROD_A;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    status_r <= status_nxt;
    an_r     <= an_nxt;
    ad_r     <= ad_nxt;
    cn_r     <= cn_nxt;
    cd_r     <= cd_nxt;
    s0_r     <= s0_nxt;
    s1_r     <= s1_nxt;
    neg_r    <= neg_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    ga_r     <= ga_nxt;
    gb_r     <= gb_nxt;
  end

  // range check and final formatting of the reduced fraction
  assign ovf  = (neg_r ? (num_r > LIMIT) : (num_r >= LIMIT)) || (den_r >= LIMIT);
  assign onum = neg_r ? (~num_r[W-1:0] + {{(W-1){1'b0}}, 1'b1}) : num_r[W-1:0];

  always_comb begin
    res.status     = status_r;
    res.result_num = '0;
    res.result_den = '0;
    if (status_r == rau_pkg::ST_OK) begin
      if (ovf) begin
        res.status = rau_pkg::ST_OVERFLOW;
      end else begin
        res.result_num = rau_pkg::FIELD_W'(onum);
        res.result_den = rau_pkg::DEN_W'(den_r[W-2:0]);
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted but sequencer stayed idle");

  a_ga_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GA |-> ga_r != '0)
    else $error("gcd operand is zero while stripping twos");

  a_ga_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GB |-> ga_r[0])
    else $error("gcd operand lost its odd invariant");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVN || state_r == S_DIVD) |-> gb_r < ga_r)
    else $error("division remainder not below divisor");
`endif

endmodule

@@ tb/rau_result_checker.sv @@
// Checker for the rational arithmetic unit: watches both stream channels, predicts
// each reduced fraction and compares it with what leaves the block.
// Depends on rau_pkg for the request and result layouts and their codes.
`timescale 1ns / 1ps

module rau_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rau_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rau_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending
);

  // sign and 64-bit magnitude, wide enough that no intermediate wraps
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } sgn_mag_t;

  rau_pkg::res_t reduced_q[$];

  function automatic sgn_mag_t to_sgn_mag(input logic [rau_pkg::FIELD_W-1:0] v);
    sgn_mag_t r;
    r.neg = v[rau_pkg::FIELD_W-1];
    r.mag = {32'd0, (v[rau_pkg::FIELD_W-1] ? (~v + 1'b1) : v)};
    return r;
  endfunction

  function automatic sgn_mag_t mul_sm(input sgn_mag_t a, input sgn_mag_t b);
    sgn_mag_t r;
    r.mag = a.mag * b.mag;
    r.neg = (r.mag != 64'd0) && (a.neg != b.neg);
    return r;
  endfunction

  function automatic sgn_mag_t add_sm(input sgn_mag_t a, input sgn_mag_t b);
    sgn_mag_t r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = b.neg;
    end
    if (r.mag == 64'd0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 64'd0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic rau_pkg::res_t reduce_request(input rau_pkg::req_t q);
    sgn_mag_t      an;
    sgn_mag_t      ad;
    sgn_mag_t      cn;
    sgn_mag_t      cd;
    sgn_mag_t      num;
    sgn_mag_t      den;
    logic [63:0]   g;
    logic [63:0]   lim;
    rau_pkg::res_t r;
    lim = 64'h8000_0000;
    an = to_sgn_mag(q.left_num);
    ad = to_sgn_mag(q.left_den);
    cn = to_sgn_mag(q.right_num);
    cd = to_sgn_mag(q.right_den);
    num = '0;
    den = '0;
    r.result_num = '0;
    r.result_den = '0;
    r.status = rau_pkg::ST_OK;
    if (ad.mag == 64'd0 || cd.mag == 64'd0) begin
      r.status = rau_pkg::ST_ZERO_DEN;
    end else if (q.mode == rau_pkg::MODE_DIV && cn.mag == 64'd0) begin
      r.status = rau_pkg::ST_DIV_ZERO;
    end else begin
      // fold each denominator's sign into its numerator
      if (ad.neg) begin
        an.neg = (an.mag != 64'd0) && !an.neg;
        ad.neg = 1'b0;
      end
      if (cd.neg) begin
        cn.neg = (cn.mag != 64'd0) && !cn.neg;
        cd.neg = 1'b0;
      end
      case (q.mode)
        rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: begin
          if (q.mode == rau_pkg::MODE_SUB) cn.neg = (cn.mag != 64'd0) && !cn.neg;
          num = add_sm(mul_sm(an, cd), mul_sm(cn, ad));
          den = mul_sm(ad, cd);
        end
        rau_pkg::MODE_MUL: begin
          num = mul_sm(an, cn);
          den = mul_sm(ad, cd);
        end
        default: begin
          num = mul_sm(an, cd);
          num.neg = (num.mag != 64'd0) && (num.neg != cn.neg);
          den.neg = 1'b0;
          den.mag = ad.mag * cn.mag;
        end
      endcase
      if (num.mag == 64'd0) begin
        num.neg = 1'b0;
        den.mag = 64'd1;
      end else begin
        g = gcd64(num.mag, den.mag);
        num.mag = num.mag / g;
        den.mag = den.mag / g;
      end
      if ((num.neg ? (num.mag > lim) : (num.mag > lim - 64'd1)) || den.mag > lim - 64'd1) begin
        r.status = rau_pkg::ST_OVERFLOW;
      end else begin
        r.result_num = num.neg ? (~num.mag[rau_pkg::FIELD_W-1:0] + 1'b1)
                               : num.mag[rau_pkg::FIELD_W-1:0];
        r.result_den = den.mag[rau_pkg::DEN_W-1:0];
      end
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch
    rau_pkg::res_t got;
    rau_pkg::res_t want;
    rau_pkg::req_t req;
    if (rst_n) begin
      // check the outgoing result first: it belongs to an older request
      if (out_tvalid && out_tready) begin
        got = out_tdata[rau_pkg::RES_W-1:0];
        if (reduced_q.size() == 0) begin
          $display("%0t: unexpected result num %0d den %0d status %0d", $time,
                   $signed(got.result_num), got.result_den, got.status);
          fail_count++;
        end else begin
          want = reduced_q.pop_front();
          if (got !== want) begin
            if (got.result_num !== want.result_num)
              $display("%0t: result_num expected %0d, got %0d", $time,
                       $signed(want.result_num), $signed(got.result_num));
            if (got.result_den !== want.result_den)
              $display("%0t: result_den expected %0d, got %0d", $time,
                       want.result_den, got.result_den);
            if (got.status !== want.status)
              $display("%0t: status expected %0d, got %0d", $time,
                       want.status, got.status);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        req = in_tdata[rau_pkg::REQ_W-1:0];
        reduced_q.push_back(reduce_request(req));
      end
      pending = reduced_q.size();
    end
  end

endmodule

@@ tb/tb_rational_arithmetic_unit.sv @@
// Top of the rational arithmetic unit testbench: clock, reset, request and result
// stimulus with random idling, and the verdict. Uses rau_pkg and rau_result_checker.
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;

  localparam int unsigned N_RANDOM     = 1700;
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam int unsigned DRAIN_CYCLES = 700;
  localparam int unsigned LONG_HOLD    = 2500;

  localparam logic [rau_pkg::FIELD_W-1:0] MIN_V = 32'h8000_0000;
  localparam logic [rau_pkg::FIELD_W-1:0] MAX_V = 32'h7FFF_FFFF;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [rau_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [rau_pkg::OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int pending;

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit long_hold_req = 1'b0;

  rational_arithmetic_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  rau_result_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // mostly small values so that results reduce and stay in range
  function automatic logic [rau_pkg::FIELD_W-1:0] pick_value(input bit for_den);
    logic [rau_pkg::FIELD_W-1:0] v;
    int                          sel;
    sel = $urandom_range(0, 99);
    if (for_den && sel < 3) begin
      v = '0;
    end else if (sel < 50) begin
      v = int'($urandom_range(0, 40)) - 20;
    end else if (sel < 70) begin
      v = int'($urandom_range(0, 131070)) - 65535;
    end else if (sel < 90) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 4))
        0:       v = MIN_V;
        1:       v = MAX_V;
        2:       v = 32'h8000_0001;
        3:       v = 32'hFFFF_FFFF;
        default: v = 32'd1;
      endcase
    end
    return v;
  endfunction

  task automatic send_req(input rau_pkg::mode_t m,
                          input logic [rau_pkg::FIELD_W-1:0] ln,
                          input logic [rau_pkg::FIELD_W-1:0] ld,
                          input logic [rau_pkg::FIELD_W-1:0] rn,
                          input logic [rau_pkg::FIELD_W-1:0] rd);
    rau_pkg::req_t                  r;
    logic [rau_pkg::IN_TDATA_W-1:0] word;
    int                             gap;
    r.mode = m;
    r.left_num = ln;
    r.left_den = ld;
    r.right_num = rn;
    r.right_den = rd;
    word = '0;
    word[rau_pkg::REQ_W-1:0] = r;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering requests until every outstanding result has left
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : receiver
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(rau_pkg::MODE_ADD, 1, 2, 1, 3);
    send_req(rau_pkg::MODE_SUB, 1, 2, 1, 2);
    send_req(rau_pkg::MODE_MUL, -2, 3, 3, 4);
    send_req(rau_pkg::MODE_DIV, 1, 2, -1, 4);
    // zero denominator wins over divide by zero
    send_req(rau_pkg::MODE_DIV, 5, 0, 0, 7);
    send_req(rau_pkg::MODE_ADD, 3, 4, 1, 0);
    send_req(rau_pkg::MODE_DIV, 3, 4, 0, 5);
    send_req(rau_pkg::MODE_ADD, 3, -4, 1, -4);
    send_req(rau_pkg::MODE_MUL, MIN_V, 1, 1, 1);
    send_req(rau_pkg::MODE_MUL, MIN_V, 1, -1, 1);
    send_req(rau_pkg::MODE_MUL, 1, MIN_V, 1, 1);
    send_req(rau_pkg::MODE_ADD, MAX_V, 1, 1, 1);
    send_req(rau_pkg::MODE_MUL, MAX_V, 1, MAX_V, 1);
    send_req(rau_pkg::MODE_ADD, 6, 8, 6, 8);
    send_req(rau_pkg::MODE_DIV, MIN_V, MIN_V, MIN_V, MIN_V);
    send_req(rau_pkg::MODE_MUL, 0, -5, 7, 3);
    send_req(rau_pkg::MODE_SUB, MAX_V, MAX_V, MIN_V, MIN_V);
    send_req(rau_pkg::MODE_DIV, 1, 3, -2, 3);
    send_req(rau_pkg::MODE_ADD, -1, -1, -1, -1);
    send_req(rau_pkg::MODE_SUB, MIN_V, 3, MAX_V, 3);
    send_req(rau_pkg::MODE_MUL, MAX_V, MIN_V, MIN_V, MAX_V);
    send_req(rau_pkg::MODE_DIV, 0, 0, 0, 0);
    send_req(rau_pkg::MODE_DIV, MAX_V, 1, 1, MAX_V);
    send_req(rau_pkg::MODE_SUB, MAX_V, MIN_V, MIN_V, MAX_V);
    hold_until_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 128 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      if (i == 600) long_hold_req = 1'b1;
      if (i == 1100) hold_until_drained();
      send_req(rau_pkg::mode_t'($urandom_range(0, 3)), pick_value(1'b0),
               pick_value(1'b1), pick_value(1'b0), pick_value(1'b1));
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rau_pkg.sv
rtl/rau_alu.sv
rtl/rau_seq.sv
rtl/rational_arithmetic_unit.sv
tb/rau_result_checker.sv
tb/tb_rational_arithmetic_unit.sv
